[sv/assert_macros.svh]
// shared assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define DFR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen outside reset
`define DFR_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[sv/dfr_pkg.sv]
package dfr_pkg;

    localparam int WINDOW_BYTES_DEF = 32;
    localparam int MAX_RESULTS      = 32;
    localparam int FRAME_OVERHEAD   = 5;

    localparam logic [7:0] START_BYTE_RST  = 8'hAA;
    localparam logic [7:0] END_BYTE_RST    = 8'hBB;
    localparam logic [4:0] MAX_PAYLOAD_RST = 5'd20;

    typedef enum logic [1:0] {
        REG_START_BYTE  = 2'd0,
        REG_END_BYTE    = 2'd1,
        REG_MAX_PAYLOAD = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRONT,
        ST_START,
        ST_LEN,
        ST_XOR,
        ST_END,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [4:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic [7:0] command;
        logic [4:0] payload_length;
        logic       has_payload;
        logic [4:0] byte_index;
        logic [7:0] payload_byte;
        logic       last;
    } beat_t;

endpackage

[sv/delimited_frame_receiver.sv]
// channel   dir  tdata                               tuser        tlast
// s_        in   rx_byte[7:0]                        -            -
// m_        out  command, payload_length,            has_payload  last
//                byte_index, payload_byte
// cfg_      in   write enable, index, 8-bit data     -            -
//
// append, rescan restart, front-byte drop, frame check and result beats all share the
// one ram read port, which reads one window byte at a time
// reset clears the scan state, head pointer, fill and result counts, config registers
// and m_tvalid; the window ram needs no clearing
// a stalled m_ side holds the scan in an emit step; s_tready is high only between bytes

module delimited_frame_receiver #(
    parameter int WINDOW_BYTES = dfr_pkg::WINDOW_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // command[7:0], payload_length[12:8],
                                   // byte_index[17:13], payload_byte[25:18]
    output logic        m_tuser,   // has_payload
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wr_data
);

    localparam int PTR_W = $clog2(WINDOW_BYTES);

    dfr_pkg::cfg_t  cfg_reg;
    dfr_pkg::beat_t beat;
    logic           out_free;
    logic           out_load;
    logic           ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [PTR_W-1:0] ram_raddr;
    logic [7:0]     ram_wdata;
    logic [7:0]     ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte  <= dfr_pkg::START_BYTE_RST;
            cfg_reg.end_byte    <= dfr_pkg::END_BYTE_RST;
            cfg_reg.max_payload <= dfr_pkg::MAX_PAYLOAD_RST;
        end else if (cfg_wr_en) begin
            case (dfr_pkg::reg_idx_t'(cfg_addr))
                dfr_pkg::REG_START_BYTE:  cfg_reg.start_byte  <= cfg_wr_data;
                dfr_pkg::REG_END_BYTE:    cfg_reg.end_byte    <= cfg_wr_data;
                dfr_pkg::REG_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_wr_data[4:0];
                default: begin
                end
            endcase
        end
    end

    dfr_ram #(
        .DEPTH(WINDOW_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dfr_scan #(
        .W(WINDOW_BYTES)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tready  (s_tready),
        .out_free  (out_free),
        .out_load  (out_load),
        .out_beat  (beat),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    dfr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .beat     (beat),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[sv/dfr_ram.sv]
module dfr_ram #(
    parameter int DEPTH = dfr_pkg::WINDOW_BYTES_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/dfr_scan.sv]
`include "assert_macros.svh"

module dfr_scan #(
    parameter int W = dfr_pkg::WINDOW_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dfr_pkg::cfg_t        cfg,
    input  logic                 s_tvalid,
    input  logic [7:0]           s_tdata,
    output logic                 s_tready,
    input  logic                 out_free,
    output logic                 out_load,
    output dfr_pkg::beat_t       out_beat,
    output logic                 ram_we,
    output logic [$clog2(W)-1:0] ram_waddr,
    output logic [7:0]           ram_wdata,
    output logic [$clog2(W)-1:0] ram_raddr,
    input  logic [7:0]           ram_rdata
);

    localparam int PTR_W = $clog2(W);
    localparam int CNT_W = $clog2(W + 1);
    localparam int SUM_W = ((PTR_W > 6) ? PTR_W : 6) + 1;
    localparam int TOT_W = (CNT_W > 9) ? CNT_W : 9;

    dfr_pkg::state_t state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [5:0]       off_reg, rd_off;
    logic [4:0]       len_reg, len_next;
    logic [7:0]       x_reg, x_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic             chk_ok_reg, chk_ok_next;
    logic [4:0]       idx_reg, idx_next;
    logic [5:0]       produced_reg, produced_next;

    logic [5:0]       drop_cnt;
    logic             drop_en;
    logic [TOT_W-1:0] total_w;
    logic [5:0]       needed;
    logic             budget_over;
    logic             idx_at_end;

    function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] w_s;
        w_s = SUM_W'(W);
        return (s >= w_s) ? PTR_W'(s - w_s) : PTR_W'(s);
    endfunction

    assign total_w     = TOT_W'(ram_rdata) + TOT_W'(dfr_pkg::FRAME_OVERHEAD);
    assign needed      = (len_reg == 5'd0) ? 6'd1 : 6'(len_reg);
    assign budget_over = (7'(produced_reg) + 7'(needed)) > 7'(dfr_pkg::MAX_RESULTS);
    assign idx_at_end  = (idx_reg == len_reg - 5'd1);

    assign ram_raddr = wrap(SUM_W'(head_reg) + SUM_W'(rd_off));
    assign ram_waddr = wrap(SUM_W'(head_reg) + SUM_W'(fill_reg));
    assign ram_wdata = s_tdata;
    assign s_tready  = (state_reg == dfr_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dfr_pkg::ST_IDLE;
            head_reg     <= '0;
            fill_reg     <= '0;
            produced_reg <= '0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            produced_reg <= produced_next;
        end
    end

    always_ff @(posedge aclk) begin
        off_reg    <= rd_off;
        len_reg    <= len_next;
        x_reg      <= x_next;
        cmd_reg    <= cmd_next;
        chk_ok_reg <= chk_ok_next;
        idx_reg    <= idx_next;
    end

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        produced_next = produced_reg;
        len_next      = len_reg;
        x_next        = x_reg;
        cmd_next      = cmd_reg;
        chk_ok_next   = chk_ok_reg;
        idx_next      = idx_reg;
        rd_off        = 6'd0;
        drop_en       = 1'b0;
        drop_cnt      = 6'd1;
        ram_we        = 1'b0;
        out_load      = 1'b0;
        out_beat      = '{command: cmd_reg, payload_length: len_reg, has_payload: 1'b1,
                          byte_index: idx_reg, payload_byte: ram_rdata, last: idx_at_end};

        case (state_reg)
            dfr_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    // full window drops the byte unstored
                    if (fill_reg < CNT_W'(W)) begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                    produced_next = '0;
                    state_next    = dfr_pkg::ST_FRONT;
                end
            end
            dfr_pkg::ST_FRONT: begin
                state_next = (fill_reg == '0) ? dfr_pkg::ST_IDLE : dfr_pkg::ST_START;
            end
            dfr_pkg::ST_START: begin
                if (ram_rdata != cfg.start_byte) begin
                    drop_en    = 1'b1;
                    state_next = dfr_pkg::ST_FRONT;
                end else if (fill_reg < CNT_W'(2)) begin
                    state_next = dfr_pkg::ST_IDLE;
                end else begin
                    rd_off     = 6'd1;
                    state_next = dfr_pkg::ST_LEN;
                end
            end
            dfr_pkg::ST_LEN: begin
                if (ram_rdata > 8'(cfg.max_payload) || total_w > TOT_W'(W)) begin
                    drop_en    = 1'b1;
                    state_next = dfr_pkg::ST_FRONT;
                end else if (TOT_W'(fill_reg) < total_w) begin
                    state_next = dfr_pkg::ST_IDLE;
                end else begin
                    len_next   = ram_rdata[4:0];
                    x_next     = ram_rdata;
                    rd_off     = 6'd2;
                    state_next = dfr_pkg::ST_XOR;
                end
            end
            dfr_pkg::ST_XOR: begin
                // off_reg is the offset of the byte now on ram_rdata
                if (off_reg == 6'(len_reg) + 6'd3) begin
                    chk_ok_next = (ram_rdata == x_reg);
                    rd_off      = 6'(len_reg) + 6'd4;
                    state_next  = dfr_pkg::ST_END;
                end else begin
                    x_next = x_reg ^ ram_rdata;
                    if (off_reg == 6'd2) begin
                        cmd_next = ram_rdata;
                    end
                    rd_off = off_reg + 6'd1;
                end
            end
            dfr_pkg::ST_END: begin
                if (ram_rdata != cfg.end_byte || !chk_ok_reg) begin
                    drop_en    = 1'b1;
                    state_next = dfr_pkg::ST_FRONT;
                end else if (budget_over) begin
                    // frame stays in the window for the next byte
                    state_next = dfr_pkg::ST_IDLE;
                end else if (len_reg == 5'd0) begin
                    state_next = dfr_pkg::ST_EMPTY;
                end else begin
                    idx_next   = 5'd0;
                    rd_off     = 6'd3;
                    state_next = dfr_pkg::ST_EMIT;
                end
            end
            dfr_pkg::ST_EMIT: begin
                rd_off = 6'd3 + 6'(idx_reg);
                if (out_free) begin
                    out_load      = 1'b1;
                    produced_next = produced_reg + 6'd1;
                    if (idx_at_end) begin
                        drop_en    = 1'b1;
                        drop_cnt   = 6'(len_reg) + 6'(dfr_pkg::FRAME_OVERHEAD);
                        state_next = dfr_pkg::ST_FRONT;
                    end else begin
                        idx_next = idx_reg + 5'd1;
                        rd_off   = 6'd4 + 6'(idx_reg);
                    end
                end
            end
            dfr_pkg::ST_EMPTY: begin
                out_beat = '{command: cmd_reg, payload_length: 5'd0, has_payload: 1'b0,
                             byte_index: 5'd0, payload_byte: 8'd0, last: 1'b1};
                if (out_free) begin
                    out_load      = 1'b1;
                    produced_next = produced_reg + 6'd1;
                    drop_en       = 1'b1;
                    drop_cnt      = 6'(dfr_pkg::FRAME_OVERHEAD);
                    state_next    = dfr_pkg::ST_FRONT;
                end
            end
            default: begin
                state_next = dfr_pkg::ST_IDLE;
            end
        endcase

        head_next = head_reg;
        if (drop_en) begin
            head_next = wrap(SUM_W'(head_reg) + SUM_W'(drop_cnt));
            fill_next = fill_reg - CNT_W'(drop_cnt);
        end
    end

    `DFR_NEVER(a_fill_bound, aclk, aresetn, fill_reg > CNT_W'(W), "window fill past depth")
    `DFR_ASSERT(a_budget, aclk, aresetn, out_load |-> produced_reg < 6'(dfr_pkg::MAX_RESULTS), "result budget exceeded")
    `DFR_ASSERT(a_no_rw_mix, aclk, aresetn, ram_we |=> state_reg == dfr_pkg::ST_FRONT, "append not followed by rescan")

endmodule

[sv/dfr_out_stage.sv]
`include "assert_macros.svh"

module dfr_out_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  dfr_pkg::beat_t beat,
    output logic           out_free,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata,  // command, payload_length, byte_index, payload_byte
    output logic           m_tuser,  // has_payload
    output logic           m_tlast
);

    logic           valid_reg, valid_next;
    dfr_pkg::beat_t beat_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            beat_reg <= beat;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, beat_reg.payload_byte, beat_reg.byte_index,
                       beat_reg.payload_length, beat_reg.command};
    assign m_tuser  = beat_reg.has_payload;
    assign m_tlast  = beat_reg.last;

    `DFR_ASSERT(a_no_overwrite, aclk, aresetn, load |-> (!valid_reg || m_tready), "pending beat overwritten")

endmodule

[bench/delimited_frame_receiver_tb.sv]
`timescale 1ns / 1ps

module delimited_frame_receiver_tb;

    localparam int WIN           = dfr_pkg::WINDOW_BYTES_DEF;
    localparam int IDLE_PCT      = 38;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 200;
    localparam int QUIET_LIMIT   = 5000;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_CHECK,
        FLAW_BAD_END,
        FLAW_CUT
    } flaw_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_addr    = dfr_pkg::REG_START_BYTE;
    logic [7:0]  cfg_wr_data = 8'd0;

    delimited_frame_receiver u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // current register values as the frame decoder sees them
    logic [7:0] cfg_start = dfr_pkg::START_BYTE_RST;
    logic [7:0] cfg_end   = dfr_pkg::END_BYTE_RST;
    logic [4:0] cfg_max   = dfr_pkg::MAX_PAYLOAD_RST;

    logic [7:0] frame_window [WIN];
    int         window_fill = 0;

    logic [7:0]     pending_bytes [$];
    dfr_pkg::beat_t expected_beats [$];

    bit s_taken   = 1'b0;
    bit calm      = 1'b0;
    bit hold_req  = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;
    int quiet     = 0;

    int errors        = 0;
    int queued_total  = 0;
    int bytes_in      = 0;
    int beats_checked = 0;
    int frames_done   = 0;
    int cfg_writes    = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- frame decoder model ----------------

    function automatic void discard_front(int count);
        if (count >= window_fill) begin
            window_fill = 0;
        end else begin
            for (int i = 0; i < window_fill - count; i++)
                frame_window[i] = frame_window[i + count];
            window_fill -= count;
        end
    endfunction

    task automatic absorb_byte(input logic [7:0] rx);
        int             len;
        int             total;
        int             produced;
        int             need;
        logic [7:0]     chk;
        bit             halt;
        dfr_pkg::beat_t b;
        produced = 0;
        halt = 1'b0;
        // a full window drops the new byte
        if (window_fill < WIN) begin
            frame_window[window_fill] = rx;
            window_fill++;
        end
        while (window_fill > 0 && !halt) begin
            if (frame_window[0] != cfg_start) begin
                discard_front(1);
            end else if (window_fill < 2) begin
                halt = 1'b1;
            end else begin
                len = int'(frame_window[1]);
                total = len + dfr_pkg::FRAME_OVERHEAD;
                if (len > int'(cfg_max) || total > WIN) begin
                    discard_front(1);
                end else if (window_fill < total) begin
                    halt = 1'b1;
                end else begin
                    chk = 8'd0;
                    for (int i = 1; i < len + 3; i++)
                        chk ^= frame_window[i];
                    if (frame_window[len + 4] != cfg_end || frame_window[len + 3] != chk) begin
                        discard_front(1);
                    end else begin
                        need = (len > 0) ? len : 1;
                        // frame stays put when this byte's beat budget would overflow
                        if (produced + need > dfr_pkg::MAX_RESULTS) begin
                            halt = 1'b1;
                        end else begin
                            for (int i = 0; i < need; i++) begin
                                b.command        = frame_window[2];
                                b.payload_length = 5'(len);
                                b.has_payload    = (len > 0);
                                b.byte_index     = (len > 0) ? 5'(i) : 5'd0;
                                b.payload_byte   = (len > 0) ? frame_window[3 + i] : 8'd0;
                                b.last           = (i + 1 == need);
                                expected_beats.push_back(b);
                            end
                            produced += need;
                            discard_front(total);
                        end
                    end
                end
            end
        end
    endtask

    // ---------------- sender ----------------

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_bytes.size() != 0 && (calm || $urandom_range(99, 0) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_bytes.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            absorb_byte(s_tdata);
            bytes_in++;
        end
    end

    // ---------------- receiver ----------------

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at beat %0d: %s got 0x%0h expected 0x%0h",
                 beats_checked, what, got, want);
        errors++;
    endtask

    task automatic check_beat();
        dfr_pkg::beat_t want;
        if (expected_beats.size() == 0) begin
            report_mismatch("beat with nothing expected, tdata", m_tdata, 32'd0);
        end else begin
            want = expected_beats.pop_front();
            if (m_tdata[7:0] != want.command)
                report_mismatch("command", 32'(m_tdata[7:0]), 32'(want.command));
            if (m_tdata[12:8] != want.payload_length)
                report_mismatch("payload_length", 32'(m_tdata[12:8]),
                                32'(want.payload_length));
            if (m_tdata[17:13] != want.byte_index)
                report_mismatch("byte_index", 32'(m_tdata[17:13]), 32'(want.byte_index));
            if (m_tdata[25:18] != want.payload_byte)
                report_mismatch("payload_byte", 32'(m_tdata[25:18]), 32'(want.payload_byte));
            if (m_tdata[31:26] != 6'd0)
                report_mismatch("tdata padding", 32'(m_tdata[31:26]), 32'd0);
            if (m_tuser != want.has_payload)
                report_mismatch("has_payload", 32'(m_tuser), 32'(want.has_payload));
            if (m_tlast != want.last)
                report_mismatch("last", 32'(m_tlast), 32'(want.last));
            if (want.last)
                frames_done++;
        end
        beats_checked++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_beat();
    end

    // no beat moving on either side for too long means the block hung
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d beats still expected",
                     QUIET_LIMIT, expected_beats.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ---------------- stimulus ----------------

    task automatic queue_byte(input logic [7:0] value);
        pending_bytes.push_back(value);
        queued_total++;
    endtask

    task automatic queue_frame(input flaw_t flaw, input int len, input logic [7:0] cmd);
        logic [7:0] bytes [$];
        logic [7:0] chk;
        int         keep;
        bytes.push_back(cfg_start);
        bytes.push_back(8'(len));
        bytes.push_back(cmd);
        for (int i = 0; i < len; i++)
            bytes.push_back(8'($urandom_range(255, 0)));
        chk = 8'd0;
        for (int i = 1; i < bytes.size(); i++)
            chk ^= bytes[i];
        if (flaw == FLAW_BAD_CHECK)
            chk ^= 8'($urandom_range(255, 1));
        bytes.push_back(chk);
        bytes.push_back((flaw == FLAW_BAD_END) ? cfg_end ^ 8'($urandom_range(255, 1))
                                               : cfg_end);
        // a cut frame stops short and leaves the decoder waiting
        keep = (flaw == FLAW_CUT) ? $urandom_range(bytes.size() - 1, 1) : bytes.size();
        for (int i = 0; i < keep; i++)
            queue_byte(bytes[i]);
    endtask

    function automatic int pick_len();
        int cap;
        cap = (cfg_max < 6) ? cfg_max : 6;
        return ($urandom_range(3, 0) == 0) ? $urandom_range(cfg_max, 0)
                                           : $urandom_range(cap, 0);
    endfunction

    // a fake frame header whose long length, if within max_payload, hides two real frames behind
    // it; they surface together once the fake frame fails its end or checksum test
    task automatic queue_shadowed_frames();
        int outer;
        outer = $urandom_range((cfg_max > 7) ? cfg_max : 7, 7);
        queue_byte(cfg_start);
        queue_byte(8'(outer));
        queue_frame(FLAW_NONE, 0, 8'($urandom_range(255, 0)));
        queue_frame(FLAW_NONE, 0, 8'($urandom_range(255, 0)));
        repeat (outer + 3 - 10)
            queue_byte(8'($urandom_range(255, 0)));
    endtask

    task automatic queue_random_sequence();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 50) begin
            queue_frame(FLAW_NONE, pick_len(), 8'($urandom_range(255, 0)));
        end else if (pick < 58) begin
            queue_frame(FLAW_BAD_CHECK, pick_len(), 8'($urandom_range(255, 0)));
        end else if (pick < 66) begin
            queue_frame(FLAW_BAD_END, pick_len(), 8'($urandom_range(255, 0)));
        end else if (pick < 71) begin
            queue_frame(FLAW_CUT, pick_len(), 8'($urandom_range(255, 0)));
        end else if (pick < 78) begin
            queue_byte(cfg_start);
            queue_byte(8'($urandom_range(255, cfg_max + 1)));
        end else if (pick < 88) begin
            repeat ($urandom_range(3, 1))
                queue_byte(8'($urandom_range(255, 0)));
        end else begin
            queue_shadowed_frames();
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = queued_total + count;
        while (queued_total < target)
            queue_random_sequence();
    endtask

    task automatic reg_write(input dfr_pkg::reg_idx_t idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            dfr_pkg::REG_START_BYTE:  cfg_start = value;
            dfr_pkg::REG_END_BYTE:    cfg_end   = value;
            dfr_pkg::REG_MAX_PAYLOAD: cfg_max   = value[4:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic load_config(input logic [7:0] start_val, input logic [7:0] end_val,
                               input logic [4:0] max_val);
        reg_write(dfr_pkg::REG_START_BYTE, start_val);
        reg_write(dfr_pkg::REG_END_BYTE, end_val);
        reg_write(dfr_pkg::REG_MAX_PAYLOAD, {3'd0, max_val});
    endtask

    // sender stays quiet until every beat is back and the scan has wound down
    task automatic settle();
        while (pending_bytes.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_beats.size() != 0)
            @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed cases under the reset register values
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_frame(FLAW_NONE, 0, 8'hFF);
        queue_frame(FLAW_NONE, 2, 8'h00);
        queue_byte(cfg_start);
        queue_byte(8'(cfg_max + 1));
        queue_frame(FLAW_BAD_CHECK, 0, 8'h5A);
        queue_frame(FLAW_BAD_END, 0, 8'hA5);
        queue_byte(cfg_start);
        queue_byte(8'd1);
        queue_byte(8'h3C);
        queue_frame(FLAW_NONE, 0, 8'h11);
        queue_shadowed_frames();
        queue_frame(FLAW_NONE, 20, 8'h80);
        run_random(30);
        settle();

        load_config(8'h00, 8'hFF, 5'd0);
        run_random(20);
        settle();

        load_config(8'hFF, 8'h00, 5'd27);
        queue_frame(FLAW_NONE, 27, 8'h7E);
        run_random(25);
        settle();

        // receiver holds off while the sender keeps offering, then no idling
        load_config(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                    5'($urandom_range(27, 0)));
        calm = 1'b1;
        hold_req = ~hold_req;
        run_random(30);
        settle();
        calm = 1'b0;

        load_config(dfr_pkg::START_BYTE_RST, dfr_pkg::END_BYTE_RST, dfr_pkg::MAX_PAYLOAD_RST);
        run_random(20);
        settle();

        $display("run covered %0d bytes, %0d beats in %0d frames, %0d register writes",
                 bytes_in, beats_checked, frames_done, cfg_writes);
        $display("mismatches: %0d", errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/dfr_pkg.sv
sv/dfr_ram.sv
sv/dfr_scan.sv
sv/dfr_out_stage.sv
sv/delimited_frame_receiver.sv
bench/delimited_frame_receiver_tb.sv
